FILE: rtl/gdiff_command_deframer_assert.svh
// ----------------------------------------------------------------------------
// GDIFF command deframer assertion macros
// Shared assertion wrappers; each expects clk_i in scope, GDC_ASSERT also rst_ni.
// ----------------------------------------------------------------------------
`ifndef GDIFF_COMMAND_DEFRAMER_ASSERT_SVH
`define GDIFF_COMMAND_DEFRAMER_ASSERT_SVH

// Checked only while out of reset
`define GDC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included
`define GDC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/gdc_pkg.sv
// ----------------------------------------------------------------------------
// GDIFF command deframer package
// Result types, opcode and result codes, argument size tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gdc_pkg;

  // Opcode boundaries
  localparam logic [7:0] OP_END     = 8'd0;
  localparam logic [7:0] OP_ADD_MAX = 8'd246;
  localparam logic [7:0] OP_COPY64  = 8'd255;

  // Result kinds
  localparam logic [1:0] KIND_LIT  = 2'd0;
  localparam logic [1:0] KIND_COPY = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_UNSUP = 2'd1;
  localparam logic [1:0] ERR_TRUNC = 2'd2;

  // Result queue geometry
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Decoder phase, one-hot
  typedef enum logic [3:0] {
    PH_OPCODE = 4'b0001,
    PH_ARGS   = 4'b0010,
    PH_ADD    = 4'b0100,
    PH_DONE   = 4'b1000
  } gdc_phase_e;

  // One result transaction
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  lit;
    logic [31:0] pos;
    logic [31:0] len;
    logic [1:0]  err;
    logic        last;
  } gdc_result_t;

  // Results produced by one accepted byte
  typedef struct packed {
    logic [1:0]  cnt;
    gdc_result_t res0;
    gdc_result_t res1;
  } gdc_push_t;

  localparam gdc_result_t RES_ZERO = '0;

  // Position argument bytes, by low opcode nibble
  function automatic logic [2:0] pos_bytes(input logic [3:0] op);
    logic [2:0] n;
    n = 3'd0;
    case (op) inside
      [4'd9:4'd11]:  n = 3'd2;
      [4'd12:4'd14]: n = 3'd4;
      default:       n = 3'd0;
    endcase
    return n;
  endfunction

  // Length (or add count) argument bytes, by low opcode nibble
  function automatic logic [2:0] len_bytes(input logic [3:0] op);
    logic [2:0] n;
    n = 3'd0;
    case (op) inside
      4'd9, 4'd12:         n = 3'd1;
      4'd7, 4'd10, 4'd13:  n = 3'd2;
      4'd8, 4'd11, 4'd14:  n = 3'd4;
      default:             n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

FILE: rtl/gdc_decoder.sv
// ----------------------------------------------------------------------------
// GDIFF command decoder
// Parser state and single-pass decode of one byte into up to two results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gdiff_command_deframer_assert.svh"

module gdc_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        diff_byte_i,
  input  logic              stream_last_i,
  output gdc_pkg::gdc_push_t push_o
);

  import gdc_pkg::*;

  gdc_phase_e  phase_q, phase_d;
  logic [3:0]  op_q, op_d;
  logic [2:0]  idx_q, idx_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] len_q, len_d;
  logic [31:0] rem_q, rem_d;

  logic [2:0]  pb, lb;
  logic [3:0]  arg_total;
  logic [2:0]  idx_inc;
  logic [31:0] pos_nx, len_nx, rem_dec;
  logic        prim_valid, trunc;
  gdc_result_t prim, trunc_res;

  // Next state and primary result
  always_comb begin
    phase_d    = phase_q;
    op_d       = op_q;
    idx_d      = idx_q;
    pos_d      = pos_q;
    len_d      = len_q;
    rem_d      = rem_q;
    prim_valid = 1'b0;
    prim       = RES_ZERO;
    pb         = pos_bytes(op_q);
    lb         = len_bytes(op_q);
    arg_total  = {1'b0, pb} + {1'b0, lb};
    idx_inc    = idx_q + 3'd1;
    rem_dec    = rem_q - 32'd1;
    pos_nx     = pos_q;
    len_nx     = len_q;
    if (idx_q < pb) begin
      pos_nx = {pos_q[23:0], diff_byte_i};
    end else begin
      len_nx = {len_q[23:0], diff_byte_i};
    end

    if (fire_i) begin
      case (phase_q)
        PH_OPCODE: begin
          if (diff_byte_i == OP_END) begin
            prim_valid = 1'b1;
            prim.kind  = KIND_END;
            phase_d    = PH_DONE;
          end else if (diff_byte_i <= OP_ADD_MAX) begin
            rem_d   = {24'd0, diff_byte_i};
            phase_d = PH_ADD;
          end else if (diff_byte_i == OP_COPY64) begin
            prim_valid = 1'b1;
            prim.kind  = KIND_ERR;
            prim.err   = ERR_UNSUP;
            phase_d    = PH_DONE;
          end else begin
            op_d    = diff_byte_i[3:0];
            idx_d   = 3'd0;
            pos_d   = 32'd0;
            len_d   = 32'd0;
            phase_d = PH_ARGS;
          end
        end
        PH_ARGS: begin
          pos_d = pos_nx;
          len_d = len_nx;
          idx_d = idx_inc;
          // counter wraps, so an eight-byte argument ends at zero
          if (idx_inc == arg_total[2:0]) begin
            idx_d = 3'd0;
            if (pb == 3'd0) begin
              rem_d   = len_nx;
              phase_d = (len_nx == 32'd0) ? PH_OPCODE : PH_ADD;
            end else begin
              prim_valid = 1'b1;
              prim.kind  = KIND_COPY;
              prim.pos   = pos_nx;
              prim.len   = len_nx;
              phase_d    = PH_OPCODE;
            end
          end
        end
        PH_ADD: begin
          prim_valid = 1'b1;
          prim.kind  = KIND_LIT;
          prim.lit   = diff_byte_i;
          rem_d      = rem_dec;
          if (rem_dec == 32'd0) begin
            phase_d = PH_OPCODE;
          end
        end
        default: begin
          // finished: byte is dropped
        end
      endcase
    end

    // Stream ended without END or error
    trunc = fire_i && stream_last_i && (phase_q != PH_DONE) && (phase_d != PH_DONE);
    if (trunc) begin
      phase_d = PH_DONE;
    end
  end

  // Result assembly: truncation error follows any primary result
  always_comb begin
    trunc_res      = RES_ZERO;
    trunc_res.kind = KIND_ERR;
    trunc_res.err  = ERR_TRUNC;
    trunc_res.last = 1'b1;
    push_o         = '0;
    if (prim_valid && trunc) begin
      push_o.cnt  = 2'd2;
      push_o.res0 = prim;
      push_o.res1 = trunc_res;
    end else if (prim_valid) begin
      push_o.cnt       = 2'd1;
      push_o.res0      = prim;
      push_o.res0.last = 1'b1;
    end else if (trunc) begin
      push_o.cnt  = 2'd1;
      push_o.res0 = trunc_res;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OPCODE;
      op_q    <= 4'd0;
      idx_q   <= 3'd0;
      pos_q   <= 32'd0;
      len_q   <= 32'd0;
      rem_q   <= 32'd0;
    end else begin
      phase_q <= phase_d;
      op_q    <= op_d;
      idx_q   <= idx_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
    end
  end

  // Assertions
  `GDC_ASSERT(a_done_silent, (phase_q == PH_DONE) |-> (push_o.cnt == 2'd0), "result after finish")
  `GDC_ASSERT(a_two_is_trunc, (push_o.cnt == 2'd2) |-> (push_o.res1.err == ERR_TRUNC), "bad second result")
  `GDC_ASSERT(a_last_finishes, (fire_i && stream_last_i) |=> (phase_q == PH_DONE), "last byte did not finish")

endmodule

FILE: rtl/gdc_out_queue.sv
// ----------------------------------------------------------------------------
// GDIFF command deframer result queue
// Small register queue that takes up to two results per cycle, emits one unless out_stall_i holds it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gdiff_command_deframer_assert.svh"

module gdc_out_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gdc_pkg::gdc_push_t  push_i,
  output logic                space_ok_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gdc_pkg::gdc_result_t out_res_o
);

  import gdc_pkg::*;

  gdc_result_t      mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic [QPtrW-1:0] wr_ptr_p1;
  logic             pop;

  // Pointer and count update
  always_comb begin
    pop       = out_valid_o && !out_stall_i;
    wr_ptr_p1 = wr_ptr_q + QPtrW'(1);
    wr_ptr_d  = wr_ptr_q + QPtrW'(push_i.cnt);
    rd_ptr_d  = rd_ptr_q + QPtrW'(pop);
    count_d   = count_q + QCntW'(push_i.cnt) - QCntW'(pop);
  end

  assign space_ok_o  = (count_q <= QCntW'(QDepth - 2));
  assign out_valid_o = (count_q != '0);
  assign out_res_o   = mem_q[rd_ptr_q];

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_p1] <= push_i.res1;
    end
  end

  // Assertions
  `GDC_ASSERT(a_count_bound, count_q <= QCntW'(QDepth), "queue overfilled")
  `GDC_ASSERT(a_push_fits, (push_i.cnt != 2'd0) |-> space_ok_o, "push without space")
  `GDC_ASSERT(a_pop_count, (pop && push_i.cnt == 2'd0) |=> (count_q == $past(count_q) - QCntW'(1)), "count lost on pop")

endmodule

FILE: rtl/gdiff_command_deframer.sv
// ----------------------------------------------------------------------------
// GDIFF command deframer
// Decodes the GDIFF command stream byte by byte into literal, copy, end and
// error result transactions.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------
//  in      | input     | in_valid_i / in_stall_o | diff_byte_i, stream_last_i
//  out     | output    | out_valid_o / out_stall_i | result_kind_o .. last_of_run_o
//
//  One byte per cycle while in_stall_o is low; the decoder updates its parser state in the accept cycle.
//  A result is registered into a 4-entry queue and is shown on out from there.
//  A byte that yields two results (a final byte that completes a literal or copy)
//  pushes both at once; in_stall_o rises when fewer than two queue slots are free.
//  Reset clears the parser to expect an opcode and empties the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdiff_command_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  diff_byte_i,
  input  logic        stream_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  literal_byte_o,
  output logic [31:0] copy_position_o,
  output logic [31:0] copy_length_o,
  output logic [1:0]  error_code_o,
  output logic        last_of_run_o
);

  import gdc_pkg::*;

  gdc_push_t   push;
  gdc_result_t out_res;
  logic        space_ok;
  logic        fire;

  assign in_stall_o = !space_ok;
  assign fire       = in_valid_i && space_ok;

  // Byte decoder
  gdc_decoder u_decoder (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .diff_byte_i   (diff_byte_i),
    .stream_last_i (stream_last_i),
    .push_o        (push)
  );

  // Result queue
  gdc_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_ok_o  (space_ok),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res)
  );

  assign result_kind_o   = out_res.kind;
  assign literal_byte_o  = out_res.lit;
  assign copy_position_o = out_res.pos;
  assign copy_length_o   = out_res.len;
  assign error_code_o    = out_res.err;
  assign last_of_run_o   = out_res.last;

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// GDIFF command deframer testbench
// Feeds one command stream into the deframer and checks each result
// transaction against a local decoder model. The run starts with a short
// table of directed bytes, then sends random well-formed commands, and
// closes the stream with one randomly chosen ending: END, a 64-bit copy,
// a cut-off command, or a final flag on a complete command. A few bytes
// that the deframer must ignore follow. Both sides insert random idle
// cycles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import gdc_pkg::*;

  // Opcodes beyond the package boundaries
  localparam logic [7:0] OP_ADD16        = 8'd247;
  localparam logic [7:0] OP_ADD32        = 8'd248;
  localparam logic [7:0] OP_COPY_P16_L8  = 8'd249;
  localparam logic [7:0] OP_COPY_P16_L16 = 8'd250;
  localparam logic [7:0] OP_COPY_P16_L32 = 8'd251;
  localparam logic [7:0] OP_COPY_P32_L8  = 8'd252;
  localparam logic [7:0] OP_COPY_P32_L16 = 8'd253;
  localparam logic [7:0] OP_COPY_P32_L32 = 8'd254;

  localparam int STREAM_BYTES = 1500;
  localparam int IDLE_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 8;

  // Ways the stream is closed
  typedef enum int {
    TAIL_END,
    TAIL_COPY64,
    TAIL_CUT,
    TAIL_LAST_CLEAN
  } tail_e;

  // One row of the directed table
  typedef struct packed {
    logic [7:0]  b;
    logic        typed;
    gdc_result_t want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  diff_byte_i = 8'h00;
  logic        stream_last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  result_kind_o;
  logic [7:0]  literal_byte_o;
  logic [31:0] copy_position_o;
  logic [31:0] copy_length_o;
  logic [1:0]  error_code_o;
  logic        last_of_run_o;

  // Decoder model state
  gdc_phase_e  dec_phase = PH_OPCODE;
  logic [7:0]  dec_op = 8'h00;
  int          dec_idx = 0;
  logic [31:0] dec_pos = '0;
  logic [31:0] dec_len = '0;
  logic [31:0] dec_add_left = '0;

  gdc_result_t due_results[$];
  logic [7:0]  cmd_bytes[$];
  dir_row_t    dir_rows[$];

  int          n_mismatch = 0;
  int          results_seen = 0;
  int          bytes_fed = 0;
  int          idle_cycles = 0;
  int          rx_wait = 0;
  bit          rx_calm = 1'b0;
  bit          tx_calm = 1'b0;
  gdc_result_t rx_want;

  gdiff_command_deframer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .diff_byte_i     (diff_byte_i),
    .stream_last_i   (stream_last_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_kind_o   (result_kind_o),
    .literal_byte_o  (literal_byte_o),
    .copy_position_o (copy_position_o),
    .copy_length_o   (copy_length_o),
    .error_code_o    (error_code_o),
    .last_of_run_o   (last_of_run_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Argument sizes per opcode
  function automatic int pos_width(input logic [7:0] op);
    case (op)
      OP_COPY_P16_L8, OP_COPY_P16_L16, OP_COPY_P16_L32: return 2;
      OP_COPY_P32_L8, OP_COPY_P32_L16, OP_COPY_P32_L32: return 4;
      default: return 0;
    endcase
  endfunction

  function automatic int len_width(input logic [7:0] op);
    case (op)
      OP_COPY_P16_L8, OP_COPY_P32_L8:                    return 1;
      OP_ADD16, OP_COPY_P16_L16, OP_COPY_P32_L16:        return 2;
      OP_ADD32, OP_COPY_P16_L32, OP_COPY_P32_L32:        return 4;
      default: return 0;
    endcase
  endfunction

  // Result with last_of_run set; the decoder clears it on a leading result
  function automatic gdc_result_t mk_res(input logic [1:0] kind, input logic [7:0] lit,
                                         input logic [31:0] pos, input logic [31:0] len,
                                         input logic [1:0] err);
    gdc_result_t r;
    r.kind = kind;
    r.lit  = lit;
    r.pos  = pos;
    r.len  = len;
    r.err  = err;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic dir_row_t plain(input logic [7:0] b);
    dir_row_t row;
    row.b     = b;
    row.typed = 1'b0;
    row.want  = RES_ZERO;
    return row;
  endfunction

  function automatic dir_row_t checked(input logic [7:0] b, input gdc_result_t want);
    dir_row_t row;
    row.b     = b;
    row.typed = 1'b1;
    row.want  = want;
    return row;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t ns: %s", $time, msg);
    n_mismatch++;
  endtask

  task automatic check_field(input string fname, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                results_seen, fname, got, want));
  endtask

  // Decode one accepted byte; results go to the due queue when keep is set
  task automatic decode_byte(input logic [7:0] b, input logic last, input bit keep);
    gdc_result_t r[2];
    int n;
    int pw;
    int lw;
    n = 0;
    if (dec_phase == PH_DONE) return;
    case (dec_phase)
      PH_OPCODE: begin
        if (b == OP_END) begin
          r[n] = mk_res(KIND_END, 8'h00, '0, '0, ERR_NONE);
          n++;
          dec_phase = PH_DONE;
        end else if (b <= OP_ADD_MAX) begin
          dec_add_left = {24'h0, b};
          dec_phase = PH_ADD;
        end else if (b == OP_COPY64) begin
          r[n] = mk_res(KIND_ERR, 8'h00, '0, '0, ERR_UNSUP);
          n++;
          dec_phase = PH_DONE;
        end else begin
          dec_op  = b;
          dec_idx = 0;
          dec_pos = '0;
          dec_len = '0;
          dec_phase = PH_ARGS;
        end
      end
      PH_ARGS: begin
        pw = pos_width(dec_op);
        lw = len_width(dec_op);
        if (dec_idx < pw) dec_pos = {dec_pos[23:0], b};
        else dec_len = {dec_len[23:0], b};
        dec_idx++;
        if (dec_idx == pw + lw) begin
          dec_idx = 0;
          if (pw == 0) begin
            // ADD16/ADD32 count complete
            dec_add_left = dec_len;
            if (dec_len == 0) dec_phase = PH_OPCODE;
            else dec_phase = PH_ADD;
          end else begin
            r[n] = mk_res(KIND_COPY, 8'h00, dec_pos, dec_len, ERR_NONE);
            n++;
            dec_phase = PH_OPCODE;
          end
        end
      end
      PH_ADD: begin
        r[n] = mk_res(KIND_LIT, b, '0, '0, ERR_NONE);
        n++;
        dec_add_left = dec_add_left - 1;
        if (dec_add_left == 0) dec_phase = PH_OPCODE;
      end
      default: ;
    endcase
    // Final flag without a clean finish means a truncated stream
    if (last && dec_phase != PH_DONE) begin
      r[n] = mk_res(KIND_ERR, 8'h00, '0, '0, ERR_TRUNC);
      n++;
      dec_phase = PH_DONE;
    end
    if (n == 2) r[0].last = 1'b0;
    if (keep)
      for (int i = 0; i < n; i++) due_results.push_back(r[i]);
  endtask

  // Send one byte with a random lead gap and wait for its acceptance
  task automatic feed_byte(input logic [7:0] b, input logic last, input bit keep);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    diff_byte_i   <= b;
    stream_last_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    decode_byte(b, last, keep);
    bytes_fed++;
  endtask

  // Hold off the sender until every due result has come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (due_results.size() != 0);
  endtask

  // Random well-formed command into cmd_bytes
  task automatic build_cmd();
    int sel;
    int cnt;
    int flavor;
    int nargs;
    logic [7:0] op;
    cmd_bytes.delete();
    cnt = 0;
    sel = $urandom_range(0, 15);
    if (sel < 5) begin
      // inline add, mostly short
      cnt = ($urandom_range(0, 15) == 0) ? $urandom_range(200, OP_ADD_MAX)
                                         : $urandom_range(1, 6);
      cmd_bytes.push_back(cnt[7:0]);
    end else if (sel < 8) begin
      // ADD16 or ADD32, sometimes with a count above one byte
      op  = (sel < 7) ? OP_ADD16 : OP_ADD32;
      cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 6);
      cmd_bytes.push_back(op);
      for (int i = len_width(op) - 1; i >= 0; i--) cmd_bytes.push_back(cnt[8*i +: 8]);
    end else begin
      // copy with all-zero, all-one or random arguments
      op     = 8'($urandom_range(OP_COPY_P16_L8, OP_COPY_P32_L32));
      flavor = $urandom_range(0, 7);
      nargs  = pos_width(op) + len_width(op);
      cmd_bytes.push_back(op);
      for (int i = 0; i < nargs; i++) begin
        if (flavor == 0) cmd_bytes.push_back(8'h00);
        else if (flavor == 1) cmd_bytes.push_back(8'hFF);
        else cmd_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    for (int i = 0; i < cnt; i++) cmd_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Send the first count bytes of cmd_bytes, flagging the last one if asked
  task automatic feed_cmd(input int count, input bit flag_last);
    for (int i = 0; i < count; i++)
      feed_byte(cmd_bytes[i], flag_last && (i == count - 1), 1'b1);
  endtask

  // Result side: random stall, compare each accepted transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing due", results_seen));
        end else begin
          rx_want = due_results.pop_front();
          check_field("kind", {30'h0, result_kind_o}, {30'h0, rx_want.kind});
          check_field("literal", {24'h0, literal_byte_o}, {24'h0, rx_want.lit});
          check_field("position", copy_position_o, rx_want.pos);
          check_field("length", copy_length_o, rx_want.len);
          check_field("error", {30'h0, error_code_o}, {30'h0, rx_want.err});
          check_field("last", {31'h0, last_of_run_o}, {31'h0, rx_want.last});
        end
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        rx_wait = rx_calm ? 0 : $urandom_range(0, 6);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall_i <= (rx_wait != 0);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    tail_e tail;
    int    cut;

    // inline add of one zero byte
    dir_rows.push_back(plain(8'd1));
    dir_rows.push_back(checked(8'h00, mk_res(KIND_LIT, 8'h00, '0, '0, ERR_NONE)));
    // widest copy with every argument bit set
    dir_rows.push_back(plain(OP_COPY_P32_L32));
    repeat (7) dir_rows.push_back(plain(8'hFF));
    dir_rows.push_back(checked(8'hFF, mk_res(KIND_COPY, 8'h00, 32'hFFFF_FFFF,
                                             32'hFFFF_FFFF, ERR_NONE)));
    // zero-length copy from position zero
    dir_rows.push_back(plain(OP_COPY_P16_L16));
    repeat (3) dir_rows.push_back(plain(8'h00));
    dir_rows.push_back(checked(8'h00, mk_res(KIND_COPY, 8'h00, '0, '0, ERR_NONE)));
    // ADD32 with zero count: next byte is an opcode again
    dir_rows.push_back(plain(OP_ADD32));
    repeat (4) dir_rows.push_back(plain(8'h00));
    // ADD16 carrying one literal
    dir_rows.push_back(plain(OP_ADD16));
    dir_rows.push_back(plain(8'h00));
    dir_rows.push_back(plain(8'h01));
    dir_rows.push_back(checked(8'hFF, mk_res(KIND_LIT, 8'hFF, '0, '0, ERR_NONE)));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (dir_rows[i]) begin
      feed_byte(dir_rows[i].b, 1'b0, !dir_rows[i].typed);
      if (dir_rows[i].typed) due_results.push_back(dir_rows[i].want);
    end
    drain_results();

    // Random well-formed commands
    while (bytes_fed < STREAM_BYTES) begin
      build_cmd();
      feed_cmd(cmd_bytes.size(), 1'b0);
      if ($urandom_range(0, 99) == 0) drain_results();
    end

    // Close the stream
    tail = tail_e'($urandom_range(0, 3));
    case (tail)
      TAIL_END:    feed_byte(OP_END, 1'($urandom_range(0, 1)), 1'b1);
      TAIL_COPY64: feed_byte(OP_COPY64, 1'($urandom_range(0, 1)), 1'b1);
      TAIL_CUT: begin
        build_cmd();
        cut = $urandom_range(1, cmd_bytes.size() - 1);
        feed_cmd(cut, 1'b1);
      end
      default: begin
        build_cmd();
        feed_cmd(cmd_bytes.size(), 1'b1);
      end
    endcase

    // Everything after the finish is ignored
    repeat (16) feed_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (n_mismatch == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
